// ===== rtl/core/bgpbps_pkg.sv =====
// ----------------------------------------------------------------------------
// bgpbps_pkg
// Shared types and defaults for the best-path select block.
// ----------------------------------------------------------------------------
package bgpbps_pkg;

	localparam int PREFIX_SLOTS_DEF      = 256;
	localparam int ROUTES_PER_PREFIX_DEF = 8;

	typedef struct packed {
		logic [31:0] next_hop;
		logic [7:0]  path_length;
		logic [31:0] local_pref;
		logic [31:0] med;
		logic [1:0]  origin;
		logic        internal;
	} route_t;

endpackage

// ===== rtl/core/bgpbps_ram.sv =====
// ----------------------------------------------------------------------------
// bgpbps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bgpbps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/bgpbps_rank.sv =====
// ----------------------------------------------------------------------------
// bgpbps_rank
// Shared route compare unit: flags a candidate that ranks strictly above
// the current best (local pref, path length, origin, MED, eBGP first).
// ----------------------------------------------------------------------------
module bgpbps_rank (
	input  bgpbps_pkg::route_t cand,
	input  bgpbps_pkg::route_t best,
	output logic               above
);

	always_comb begin
		priority if (cand.local_pref != best.local_pref) begin
			above = cand.local_pref > best.local_pref;
		end else if (cand.path_length != best.path_length) begin
			above = cand.path_length < best.path_length;
		end else if (cand.origin != best.origin) begin
			above = cand.origin < best.origin;
		end else if (cand.med != best.med) begin
			above = cand.med < best.med;
		end else if (cand.internal != best.internal) begin
			above = cand.internal < best.internal;
		end else begin
			above = 1'b0;
		end
	end

endmodule

// ===== rtl/core/bgp_best_path_select.sv =====
// ----------------------------------------------------------------------------
// bgp_best_path_select
// Per-prefix route store with sequential best-path scan over one compare unit.
// ----------------------------------------------------------------------------
// Flow: each input beat is stalled out until its result beat is issued; during
//   the scan, one stored route is read and ranked per cycle through the
//   single route RAM read port and the compare unit.
// Reset: clears control state, then sweeps every slot of the per-prefix
//   table; input is stalled until the sweep ends.
// ----------------------------------------------------------------------------
module bgp_best_path_select #(
	parameter int PREFIX_SLOTS      = bgpbps_pkg::PREFIX_SLOTS_DEF,
	parameter int ROUTES_PER_PREFIX = bgpbps_pkg::ROUTES_PER_PREFIX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  prefix_index,
	input  logic [31:0] next_hop,
	input  logic [7:0]  path_length,
	input  logic [31:0] local_pref,
	input  logic [31:0] med,
	input  logic [1:0]  origin,
	input  logic        internal,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic        changed,
	output logic [2:0]  best_slot,
	output logic [31:0] best_next_hop,
	output logic [7:0]  best_path_length,
	output logic [31:0] best_local_pref,
	output logic [31:0] best_med,
	output logic [1:0]  best_origin,
	output logic        best_internal
);

	localparam int SLOT_W = (PREFIX_SLOTS > 1) ? $clog2(PREFIX_SLOTS) : 1;
	localparam int IDX_W  = (ROUTES_PER_PREFIX > 1) ? $clog2(ROUTES_PER_PREFIX) : 1;
	localparam int CNT_W  = $clog2(ROUTES_PER_PREFIX + 1);
	localparam int TOTAL  = PREFIX_SLOTS * ROUTES_PER_PREFIX;
	localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int SE_W   = CNT_W + 33;
	localparam int RT_W   = $bits(bgpbps_pkg::route_t);

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_SLOT,
		ST_SCAN,
		ST_DRAIN,
		ST_UPD,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [SLOT_W-1:0]   clr_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [ADDR_W-1:0]   base_q;
	bgpbps_pkg::route_t  new_q;
	logic                status_q;
	logic [CNT_W-1:0]    new_cnt_q;
	logic [IDX_W-1:0]    last_q;
	logic [IDX_W-1:0]    idx_q;
	logic                bv_q;
	logic [31:0]         rec_q;
	logic                changed_q;
	bgpbps_pkg::route_t  best_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic                out_valid_q;
	logic                out_status_q;
	logic                out_changed_q;
	logic [2:0]          out_slot_q;
	bgpbps_pkg::route_t  out_route_q;

	logic [SLOT_W-1:0]   slot_lut [256];
	logic [SLOT_W-1:0]   slot_in;
	logic                accept;

	logic                se_we;
	logic [SLOT_W-1:0]   se_waddr;
	logic [SE_W-1:0]     se_wdata;
	logic [SE_W-1:0]     se_rdata;
	logic [CNT_W-1:0]    se_cnt;
	logic                se_bv;
	logic [31:0]         se_hop;

	logic                rt_we;
	logic [ADDR_W-1:0]   rt_waddr;
	logic                rt_re;
	logic [ADDR_W-1:0]   rt_raddr;
	logic [RT_W-1:0]     rt_rdata;
	bgpbps_pkg::route_t  cand;
	logic                above;

	for (genvar g = 0; g < 256; g++) begin : g_slot_lut
		assign slot_lut[g] = SLOT_W'(g % PREFIX_SLOTS);
	end

	assign slot_in  = slot_lut[prefix_index];
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	assign se_cnt = se_rdata[SE_W-1:33];
	assign se_bv  = se_rdata[32];
	assign se_hop = se_rdata[31:0];

	always_comb begin
		se_we    = 1'b0;
		se_waddr = slot_q;
		se_wdata = '0;
		if (state_q == ST_CLR) begin
			se_we    = 1'b1;
			se_waddr = clr_q;
		end else if (state_q == ST_UPD) begin
			se_we    = 1'b1;
			se_wdata = {new_cnt_q, 1'b1, best_q.next_hop};
		end
	end

	bgpbps_ram #(
		.WIDTH (SE_W),
		.DEPTH (PREFIX_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (se_we),
		.waddr (se_waddr),
		.wdata (se_wdata),
		.re    (accept),
		.raddr (slot_in),
		.rdata (se_rdata)
	);

	assign rt_we    = (state_q == ST_SLOT) && (se_cnt < CNT_W'(ROUTES_PER_PREFIX));
	assign rt_waddr = base_q + ADDR_W'(se_cnt);
	assign rt_re    = (state_q == ST_SCAN);
	assign rt_raddr = base_q + ADDR_W'(idx_q);

	bgpbps_ram #(
		.WIDTH (RT_W),
		.DEPTH (TOTAL)
	) u_route_ram (
		.clk   (clk),
		.we    (rt_we),
		.waddr (rt_waddr),
		.wdata (new_q),
		.re    (rt_re),
		.raddr (rt_raddr),
		.rdata (rt_rdata)
	);

	assign cand = bgpbps_pkg::route_t'(rt_rdata);

	bgpbps_rank u_rank (
		.cand  (cand),
		.best  (best_q),
		.above (above)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLR;
			clr_q         <= '0;
			slot_q        <= '0;
			base_q        <= '0;
			new_q         <= '0;
			status_q      <= 1'b0;
			new_cnt_q     <= '0;
			last_q        <= '0;
			idx_q         <= '0;
			bv_q          <= 1'b0;
			rec_q         <= '0;
			changed_q     <= 1'b0;
			best_q        <= '0;
			best_idx_q    <= '0;
			rd_vld_s1     <= 1'b0;
			rd_idx_s1     <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= 1'b0;
			out_changed_q <= 1'b0;
			out_slot_q    <= '0;
			out_route_q   <= '0;
		end else begin
			rd_vld_s1 <= rt_re;
			rd_idx_s1 <= idx_q;
			if (rd_vld_s1 && ((rd_idx_s1 == '0) || above)) begin
				best_q     <= cand;
				best_idx_q <= rd_idx_s1;
			end
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(PREFIX_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						slot_q               <= slot_in;
						base_q               <= ADDR_W'(slot_in) * ADDR_W'(ROUTES_PER_PREFIX);
						new_q.next_hop       <= next_hop;
						new_q.path_length    <= path_length;
						new_q.local_pref     <= local_pref;
						new_q.med            <= med;
						new_q.origin         <= origin;
						new_q.internal       <= internal;
						state_q              <= ST_SLOT;
					end
				end
				ST_SLOT: begin
					bv_q  <= se_bv;
					rec_q <= se_hop;
					idx_q <= '0;
					if (se_cnt < CNT_W'(ROUTES_PER_PREFIX)) begin
						status_q  <= 1'b0;
						new_cnt_q <= se_cnt + 1'b1;
						last_q    <= IDX_W'(se_cnt);
					end else begin
						status_q  <= 1'b1;
						new_cnt_q <= se_cnt;
						last_q    <= IDX_W'(ROUTES_PER_PREFIX - 1);
					end
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == last_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					changed_q <= !bv_q || (rec_q != best_q.next_hop);
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						out_status_q  <= status_q;
						out_changed_q <= changed_q;
						out_slot_q    <= 3'(best_idx_q);
						out_route_q   <= best_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = out_status_q;
	assign changed          = out_changed_q;
	assign best_slot        = out_slot_q;
	assign best_next_hop    = out_route_q.next_hop;
	assign best_path_length = out_route_q.path_length;
	assign best_local_pref  = out_route_q.local_pref;
	assign best_med         = out_route_q.med;
	assign best_origin      = out_route_q.origin;
	assign best_internal    = out_route_q.internal;

	a_scan_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> idx_q <= last_q)
		else $error("scan index ran past the end of the route list");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |-> new_cnt_q != '0)
		else $error("route count is zero at update");

	a_best_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |-> best_idx_q <= last_q)
		else $error("best route index outside the scanned list");

	a_full_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SLOT && !rt_we |=> status_q)
		else $error("route dropped without full status");

endmodule

// ===== dv/tb_bgp_best_path_select.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bgp_best_path_select
// Self-checking bench for the per-prefix best-path selector. Route updates
// are driven with random gaps and checked against a behavioral route table
// that appends, ranks and tracks the recorded best next hop per prefix.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic                 status;
	logic                 changed;
	logic [2:0]           slot;
	bgpbps_pkg::route_t   route;
} path_result_t;

class route_scoreboard;
	localparam int SLOTS = bgpbps_pkg::PREFIX_SLOTS_DEF;
	localparam int DEPTH = bgpbps_pkg::ROUTES_PER_PREFIX_DEF;

	bgpbps_pkg::route_t routes [SLOTS][DEPTH];
	int unsigned        fill [SLOTS];
	bit                 best_known [SLOTS];
	logic [31:0]        best_hop [SLOTS];
	path_result_t       pending [$];
	int                 mismatches;

	function new();
		mismatches = 0;
		for (int p = 0; p < SLOTS; p++) begin
			fill[p] = 0;
			best_known[p] = 1'b0;
		end
	endfunction

	function bit outranks(bgpbps_pkg::route_t a, bgpbps_pkg::route_t b);
		if (a.local_pref != b.local_pref)
			return a.local_pref > b.local_pref;
		if (a.path_length != b.path_length)
			return a.path_length < b.path_length;
		if (a.origin != b.origin)
			return a.origin < b.origin;
		if (a.med != b.med)
			return a.med < b.med;
		if (a.internal != b.internal)
			return a.internal < b.internal;
		return 1'b0;
	endfunction

	function void note_update(logic [7:0] pfx, bgpbps_pkg::route_t r);
		path_result_t want;
		int unsigned  n;
		int unsigned  top;
		want = '0;
		n = fill[pfx];
		if (n < DEPTH) begin
			routes[pfx][n] = r;
			n++;
			fill[pfx] = n;
		end else begin
			want.status = 1'b1;
		end
		top = 0;
		for (int i = 1; i < n; i++)
			if (outranks(routes[pfx][i], routes[pfx][top]))
				top = i;
		if (!best_known[pfx] || best_hop[pfx] != routes[pfx][top].next_hop) begin
			best_known[pfx] = 1'b1;
			best_hop[pfx] = routes[pfx][top].next_hop;
			want.changed = 1'b1;
		end
		want.slot = top[2:0];
		want.route = routes[pfx][top];
		pending.insert(pending.size(), want);
	endfunction

	function void fault(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch: %s", $time, msg);
	endfunction

	function void compare(string name, logic [31:0] want, logic [31:0] seen);
		if (seen !== want)
			fault($sformatf("%s expected %0h got %0h", name, want, seen));
	endfunction

	function void check_result(path_result_t seen);
		path_result_t want;
		if (pending.size() == 0) begin
			fault("result beat with no update outstanding");
			return;
		end
		want = pending.pop_front();
		compare("status", 32'(want.status), 32'(seen.status));
		compare("changed", 32'(want.changed), 32'(seen.changed));
		compare("best_slot", 32'(want.slot), 32'(seen.slot));
		compare("best_next_hop", want.route.next_hop, seen.route.next_hop);
		compare("best_path_length", 32'(want.route.path_length),
			32'(seen.route.path_length));
		compare("best_local_pref", want.route.local_pref, seen.route.local_pref);
		compare("best_med", want.route.med, seen.route.med);
		compare("best_origin", 32'(want.route.origin), 32'(seen.route.origin));
		compare("best_internal", 32'(want.route.internal),
			32'(seen.route.internal));
	endfunction

	function int outstanding();
		return pending.size();
	endfunction
endclass

module tb_bgp_best_path_select;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  prefix_index;
	logic [31:0] next_hop;
	logic [7:0]  path_length;
	logic [31:0] local_pref;
	logic [31:0] med;
	logic [1:0]  origin;
	logic        internal;
	logic        out_valid;
	logic        out_stall;
	logic        status;
	logic        changed;
	logic [2:0]  best_slot;
	logic [31:0] best_next_hop;
	logic [7:0]  best_path_length;
	logic [31:0] best_local_pref;
	logic [31:0] best_med;
	logic [1:0]  best_origin;
	logic        best_internal;

	route_scoreboard sb = new();
	bit              quiet = 1'b0;

	logic [31:0] hop_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0A00_0001,
		32'hC0A8_0001, 32'h0A00_0002, 32'h7F00_0001};
	logic [31:0] pref_levels [4] = '{32'd0, 32'd100, 32'd200, 32'hFFFF_FFFF};

	bgp_best_path_select DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.prefix_index(prefix_index),
		.next_hop(next_hop),
		.path_length(path_length),
		.local_pref(local_pref),
		.med(med),
		.origin(origin),
		.internal(internal),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.changed(changed),
		.best_slot(best_slot),
		.best_next_hop(best_next_hop),
		.best_path_length(best_path_length),
		.best_local_pref(best_local_pref),
		.best_med(best_med),
		.best_origin(best_origin),
		.best_internal(best_internal)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bgpbps_pkg::route_t route_of(logic [31:0] hop, logic [7:0] plen,
			logic [31:0] lp, logic [31:0] m, logic [1:0] org, logic ibgp);
		bgpbps_pkg::route_t r;
		r.next_hop = hop;
		r.path_length = plen;
		r.local_pref = lp;
		r.med = m;
		r.origin = org;
		r.internal = ibgp;
		return r;
	endfunction

	function automatic bgpbps_pkg::route_t random_route();
		if ($urandom_range(0, 9) < 3)
			return route_of($urandom, 8'($urandom), $urandom, $urandom,
				2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
		return route_of(hop_pool[3'($urandom_range(0, 5))], 8'($urandom_range(0, 3)),
			pref_levels[2'($urandom_range(0, 3))], $urandom_range(0, 3),
			2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
	endfunction

	task automatic send_update(input logic [7:0] pfx, input bgpbps_pkg::route_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		prefix_index <= pfx;
		next_hop <= r.next_hop;
		path_length <= r.path_length;
		local_pref <= r.local_pref;
		med <= r.med;
		origin <= r.origin;
		internal <= r.internal;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_update(pfx, r);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	// result side: random stall runs
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			n = pick_gap();
			if (n > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			repeat ($urandom_range(0, 15)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		path_result_t seen;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			seen.status = status;
			seen.changed = changed;
			seen.slot = best_slot;
			seen.route = route_of(best_next_hop, best_path_length, best_local_pref,
				best_med, best_origin, best_internal);
			sb.check_result(seen);
		end
	end

	initial begin
		logic [7:0] hot [32];
		logic [7:0] pfx;
		arst_n = 1'b0;
		in_valid = 1'b0;
		prefix_index = '0;
		next_hop = '0;
		path_length = '0;
		local_pref = '0;
		med = '0;
		origin = '0;
		internal = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all-zero route, then all-ones route with worst origin
		send_update(8'd0, route_of(32'h0, 8'd0, 32'h0, 32'h0, 2'd0, 1'b0));
		send_update(8'd0, route_of('1, 8'hFF, '1, '1, 2'd3, 1'b1));
		// each tie-break step in turn, then a tie, a same-hop win and a full list
		send_update(8'd1, route_of(32'h0A00_0001, 8'd5, 32'd100, 32'd50, 2'd1, 1'b1));
		send_update(8'd1, route_of(32'h0A00_0002, 8'd5, 32'd100, 32'd50, 2'd1, 1'b0));
		send_update(8'd1, route_of(32'h0A00_0003, 8'd5, 32'd100, 32'd40, 2'd1, 1'b1));
		send_update(8'd1, route_of(32'h0A00_0004, 8'd5, 32'd100, 32'd60, 2'd0, 1'b1));
		send_update(8'd1, route_of(32'h0A00_0005, 8'd4, 32'd100, 32'd60, 2'd2, 1'b1));
		send_update(8'd1, route_of(32'h0A00_0006, 8'd9, 32'd101, 32'd60, 2'd2, 1'b1));
		send_update(8'd1, route_of(32'h0A00_0099, 8'd9, 32'd101, 32'd60, 2'd2, 1'b1));
		send_update(8'd1, route_of(32'h0A00_0006, 8'd9, 32'd102, 32'd60, 2'd2, 1'b1));
		send_update(8'd1, route_of(32'h0A00_0007, 8'd0, '1, 32'd0, 2'd0, 1'b0));
		send_update(8'd1, route_of(32'h0A00_0008, 8'd0, '1, 32'd0, 2'd0, 1'b0));
		send_update(8'd255, route_of(32'h8000_0000, 8'hFF, 32'h8000_0000, 32'd0, 2'd3, 1'b0));
		send_update(8'd255, route_of(32'h8000_0001, 8'hFF, 32'h8000_0000, 32'd0, 2'd2, 1'b0));
		send_update(8'd128, route_of(32'h0102_0304, 8'd7, 32'd5, '1, 2'd1, 1'b0));
		send_update(8'd128, route_of(32'h0506_0708, 8'd7, 32'd5, 32'd0, 2'd1, 1'b1));
		drain_results();

		foreach (hot[i])
			hot[i] = 8'($urandom_range(0, 255));
		for (int k = 0; k < 1535; k++) begin
			if (k == 500 || k == 1000)
				drain_results();
			quiet = (k >= 700 && k < 850);
			if ($urandom_range(0, 9) < 4)
				pfx = hot[5'($urandom_range(0, 31))];
			else
				pfx = 8'($urandom_range(0, 255));
			send_update(pfx, random_route());
		end
		quiet = 1'b0;

		drain_results();
		repeat (32) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
